@@ sv/bfmd_pkg.sv @@
package bfmd_pkg;

    // default build-time limits
    localparam int MAX_BODY_BYTES_DEF   = 4096;
    localparam int CODE_CHARS_MAX_DEF   = 3;
    localparam int LENGTH_CHARS_MAX_DEF = 15;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int CODE_W   = 24;
    localparam int FCOUNT_W = 4;
    localparam int OUT_TDATA_W = 56;

    // characters of the framing
    localparam logic [7:0] CHR_BAR   = 8'h7C;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    // reset values of the configuration registers
    localparam logic [7:0]       VERSION_RST  = 8'h31;
    localparam logic [LEN_W-1:0] MAX_BODY_RST = 13'd4096;

    // configuration register indexes
    typedef enum logic {
        REG_EXPECTED_VERSION = 1'b0,
        REG_MAX_BODY_LENGTH  = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_VBAR = 3'd1,
        PH_CODE = 3'd2,
        PH_LEAD = 3'd3,
        PH_NUM  = 3'd4,
        PH_BODY = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_VERSION = 2'd1,
        ST_ILL     = 2'd2,
        ST_DISC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              link_closed;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_version;
        logic [LEN_W-1:0]  max_body_length;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              end_of_message;
        t_status           status;
        logic [CODE_W-1:0] code_chars;
        logic [1:0]        code_count;
        logic [LEN_W-1:0]  body_length;
    } t_result;

    // handshake between the stages
    typedef struct packed {
        logic advance;
        logic load;
    } t_stage_ctl;

endpackage

@@ sv/bfmd_in_stage.sv @@
module bfmd_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bfmd_pkg::t_in_item i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output bfmd_pkg::t_in_item o_item
);

    logic               r_valid;
    bfmd_pkg::t_in_item r_item;

    // room when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/bfmd_parser.sv @@
module bfmd_parser #(
    parameter int MAX_BODY_BYTES   = bfmd_pkg::MAX_BODY_BYTES_DEF,
    parameter int CODE_CHARS_MAX   = bfmd_pkg::CODE_CHARS_MAX_DEF,
    parameter int LENGTH_CHARS_MAX = bfmd_pkg::LENGTH_CHARS_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  bfmd_pkg::t_in_item i_item,
    input  bfmd_pkg::t_cfg     i_cfg,
    output logic               o_has_result,
    output bfmd_pkg::t_result  o_result
);

    localparam int AW   = $clog2(MAX_BODY_BYTES + 1);
    localparam int MW   = AW + 4;
    localparam int CMPW = (AW > bfmd_pkg::LEN_W) ? AW : bfmd_pkg::LEN_W;

    bfmd_pkg::t_phase                 r_phase, n_phase;
    logic [bfmd_pkg::FCOUNT_W-1:0]    r_field_count, n_field_count;
    logic [bfmd_pkg::CODE_W-1:0]      r_code_store, n_code_store;
    logic [AW-1:0]                    r_length_accum, n_length_accum;
    logic                             r_length_overflow, n_length_overflow;
    logic                             r_length_digits_done, n_length_digits_done;
    logic                             r_length_negative, n_length_negative;
    logic [AW-1:0]                    r_body_remaining, n_body_remaining;
    logic [AW-1:0]                    r_declared_length, n_declared_length;

    logic [7:0]    c;
    logic          digit;
    logic          is_ws;
    logic          is_atoi_ws;
    logic [MW-1:0] acc_next;
    logic          acc_over;
    logic          len_bad;
    logic          code_full;
    logic          len_full;
    logic          last_body;

    assign c     = i_item.rx_byte;
    assign digit = (c >= bfmd_pkg::CHR_ZERO) && (c <= bfmd_pkg::CHR_NINE);
    assign is_ws = (c == bfmd_pkg::CHR_LF) || (c == bfmd_pkg::CHR_CR)
                || (c == bfmd_pkg::CHR_SPACE);
    assign is_atoi_ws = is_ws || (c == bfmd_pkg::CHR_TAB) || (c == bfmd_pkg::CHR_VT)
                     || (c == bfmd_pkg::CHR_FF);

    // accum * 10 + digit, as two shifts and adds
    assign acc_next = {1'b0, r_length_accum, 3'b000} + {3'b000, r_length_accum, 1'b0}
                    + MW'(c[3:0]);
    assign acc_over = acc_next > MW'(MAX_BODY_BYTES);

    // accum never exceeds MAX_BODY_BYTES, so the register limit alone decides
    assign len_bad = r_length_negative || r_length_overflow
                  || (r_length_accum == '0)
                  || (CMPW'(r_length_accum) > CMPW'(i_cfg.max_body_length));

    assign code_full = r_field_count >= bfmd_pkg::FCOUNT_W'(CODE_CHARS_MAX);
    assign len_full  = r_field_count >= bfmd_pkg::FCOUNT_W'(LENGTH_CHARS_MAX);
    assign last_body = r_body_remaining <= AW'(1);

    // next state
    always_comb begin
        n_phase              = r_phase;
        n_field_count        = r_field_count;
        n_code_store         = r_code_store;
        n_length_accum       = r_length_accum;
        n_length_overflow    = r_length_overflow;
        n_length_digits_done = r_length_digits_done;
        n_length_negative    = r_length_negative;
        n_body_remaining     = r_body_remaining;
        n_declared_length    = r_declared_length;
        if (i_item.link_closed) begin
            n_phase = bfmd_pkg::PH_IDLE;
        end else begin
            unique case (r_phase)
                bfmd_pkg::PH_IDLE: begin
                    if (!is_ws && (c == i_cfg.expected_version)) begin
                        n_phase = bfmd_pkg::PH_VBAR;
                    end
                end
                bfmd_pkg::PH_VBAR: begin
                    if (c == bfmd_pkg::CHR_BAR) begin
                        n_phase       = bfmd_pkg::PH_CODE;
                        n_field_count = '0;
                    end else begin
                        n_phase = bfmd_pkg::PH_IDLE;
                    end
                end
                bfmd_pkg::PH_CODE: begin
                    if (c == bfmd_pkg::CHR_BAR) begin
                        n_phase       = bfmd_pkg::PH_LEAD;
                        n_field_count = '0;
                    end else if (code_full) begin
                        n_phase = bfmd_pkg::PH_IDLE;
                    end else begin
                        // only the first three characters are kept
                        unique case (r_field_count)
                            4'd0:    n_code_store[23:16] = r_code_store[23:16] | c;
                            4'd1:    n_code_store[15:8]  = r_code_store[15:8] | c;
                            4'd2:    n_code_store[7:0]   = r_code_store[7:0] | c;
                            default: n_code_store        = r_code_store;
                        endcase
                        n_field_count = r_field_count + 1'b1;
                    end
                end
                bfmd_pkg::PH_LEAD, bfmd_pkg::PH_NUM: begin
                    if (c == bfmd_pkg::CHR_BAR) begin
                        if (len_bad) begin
                            n_phase = bfmd_pkg::PH_IDLE;
                        end else begin
                            n_phase           = bfmd_pkg::PH_BODY;
                            n_body_remaining  = r_length_accum;
                            n_declared_length = r_length_accum;
                        end
                    end else if (len_full) begin
                        n_phase = bfmd_pkg::PH_IDLE;
                    end else begin
                        n_field_count = r_field_count + 1'b1;
                        if (r_phase == bfmd_pkg::PH_LEAD && is_atoi_ws) begin
                            n_phase = bfmd_pkg::PH_LEAD;
                        end else if (r_phase == bfmd_pkg::PH_LEAD && c == bfmd_pkg::CHR_MINUS) begin
                            n_phase           = bfmd_pkg::PH_NUM;
                            n_length_negative = 1'b1;
                        end else if (r_phase == bfmd_pkg::PH_LEAD && c == bfmd_pkg::CHR_PLUS) begin
                            n_phase = bfmd_pkg::PH_NUM;
                        end else if (r_phase == bfmd_pkg::PH_NUM && r_length_digits_done) begin
                            n_phase = bfmd_pkg::PH_NUM;
                        end else if (digit) begin
                            n_phase = bfmd_pkg::PH_NUM;
                            if (!r_length_overflow) begin
                                if (acc_over) begin
                                    n_length_overflow = 1'b1;
                                    n_length_accum    = '0;
                                end else begin
                                    n_length_accum = acc_next[AW-1:0];
                                end
                            end
                        end else begin
                            n_phase              = bfmd_pkg::PH_NUM;
                            n_length_digits_done = 1'b1;
                        end
                    end
                end
                bfmd_pkg::PH_BODY: begin
                    if (last_body) begin
                        n_phase = bfmd_pkg::PH_IDLE;
                    end else begin
                        n_body_remaining = r_body_remaining - 1'b1;
                    end
                end
                default: n_phase = bfmd_pkg::PH_IDLE;
            endcase
        end

        // every return to idle starts a clean frame
        if (n_phase == bfmd_pkg::PH_IDLE) begin
            n_field_count        = '0;
            n_code_store         = '0;
            n_length_accum       = '0;
            n_length_overflow    = 1'b0;
            n_length_digits_done = 1'b0;
            n_length_negative    = 1'b0;
            n_body_remaining     = '0;
            n_declared_length    = '0;
        end
    end

    // result of this beat
    always_comb begin
        o_has_result            = 1'b0;
        o_result.data_byte      = '0;
        o_result.has_byte       = 1'b0;
        o_result.end_of_message = 1'b1;
        o_result.status         = bfmd_pkg::ST_OK;
        o_result.code_chars     = r_code_store;
        o_result.body_length    = '0;
        priority if (r_code_store[7:0] != 8'h00) begin
            o_result.code_count = 2'd3;
        end else if (r_code_store[15:8] != 8'h00) begin
            o_result.code_count = 2'd2;
        end else if (r_code_store[23:16] != 8'h00) begin
            o_result.code_count = 2'd1;
        end else begin
            o_result.code_count = 2'd0;
        end

        if (i_item.link_closed) begin
            o_has_result    = 1'b1;
            o_result.status = bfmd_pkg::ST_DISC;
        end else begin
            unique case (r_phase)
                bfmd_pkg::PH_IDLE: begin
                    if (!is_ws && (c != i_cfg.expected_version)) begin
                        o_has_result    = 1'b1;
                        o_result.status = bfmd_pkg::ST_VERSION;
                    end
                end
                bfmd_pkg::PH_VBAR: begin
                    if (c != bfmd_pkg::CHR_BAR) begin
                        o_has_result    = 1'b1;
                        o_result.status = bfmd_pkg::ST_ILL;
                    end
                end
                bfmd_pkg::PH_CODE: begin
                    if (c != bfmd_pkg::CHR_BAR && code_full) begin
                        o_has_result    = 1'b1;
                        o_result.status = bfmd_pkg::ST_ILL;
                    end
                end
                bfmd_pkg::PH_LEAD, bfmd_pkg::PH_NUM: begin
                    if ((c == bfmd_pkg::CHR_BAR) ? len_bad : len_full) begin
                        o_has_result    = 1'b1;
                        o_result.status = bfmd_pkg::ST_ILL;
                    end
                end
                bfmd_pkg::PH_BODY: begin
                    o_has_result            = 1'b1;
                    o_result.data_byte      = c;
                    o_result.has_byte       = 1'b1;
                    o_result.end_of_message = last_body;
                    o_result.body_length    = bfmd_pkg::LEN_W'(r_declared_length);
                    if (last_body && c != bfmd_pkg::CHR_BAR) begin
                        o_result.status = bfmd_pkg::ST_ILL;
                    end
                end
                default: o_has_result = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase              <= bfmd_pkg::PH_IDLE;
            r_field_count        <= '0;
            r_code_store         <= '0;
            r_length_accum       <= '0;
            r_length_overflow    <= 1'b0;
            r_length_digits_done <= 1'b0;
            r_length_negative    <= 1'b0;
            r_body_remaining     <= '0;
            r_declared_length    <= '0;
        end else if (i_advance) begin
            r_phase              <= n_phase;
            r_field_count        <= n_field_count;
            r_code_store         <= n_code_store;
            r_length_accum       <= n_length_accum;
            r_length_overflow    <= n_length_overflow;
            r_length_digits_done <= n_length_digits_done;
            r_length_negative    <= n_length_negative;
            r_body_remaining     <= n_body_remaining;
            r_declared_length    <= n_declared_length;
        end
    end

endmodule

@@ sv/bfmd_out_stage.sv @@
module bfmd_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfmd_pkg::t_stage_ctl i_ctl,
    input  bfmd_pkg::t_result    i_result,
    input  logic                 i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output bfmd_pkg::t_result    o_result
);

    logic              r_valid;
    bfmd_pkg::t_result r_result;

    // the register can take a new result when empty or drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.advance && i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance && i_ctl.load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ sv/bar_framed_message_deframer.sv @@
// Deframer for V|CODE|LEN|body messages on a byte stream. One byte is taken
// per beat on s_axis and the block sustains one byte per clock while
// m_axis_tready stays high. A byte is held in the input register until the
// result register has room, is parsed combinationally, and its result is
// registered in the result register, from which m_axis takes the result beat.
// Header bytes and skipped whitespace produce no output beat; each body byte
// produces one. A header error or a dropped link produces one beat with tuser
// low, tlast high and the error status; a body whose last byte is not a bar
// ends with that byte, tuser high, tlast high and status ill-formed.
// s_axis_tready follows m_axis_tready combinationally when both stages hold a
// beat. Configuration writes are always accepted and must be issued only while
// the block is idle.
module bar_framed_message_deframer #(
    parameter int MAX_BODY_BYTES   = bfmd_pkg::MAX_BODY_BYTES_DEF,
    parameter int CODE_CHARS_MAX   = bfmd_pkg::CODE_CHARS_MAX_DEF,
    parameter int LENGTH_CHARS_MAX = bfmd_pkg::LENGTH_CHARS_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input byte stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // rx_byte
    input  logic                             s_axis_tuser,  // link_closed
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // data_byte[7:0], status[9:8], code_chars[33:10], code_count[35:34],
    // body_length[48:36], zero fill [55:49]
    output logic [bfmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser,  // has_byte
    output logic                             m_axis_tlast,  // end_of_message
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [bfmd_pkg::LEN_W-1:0]       i_cfg_data
);

    bfmd_pkg::t_cfg       r_cfg;
    bfmd_pkg::t_in_item   in_item;
    bfmd_pkg::t_in_item   held_item;
    logic                 held_valid;
    logic                 out_free;
    logic                 has_result;
    bfmd_pkg::t_result    result;
    bfmd_pkg::t_result    out_result;
    bfmd_pkg::t_stage_ctl ctl;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= bfmd_pkg::VERSION_RST;
            r_cfg.max_body_length  <= bfmd_pkg::MAX_BODY_RST;
        end else if (i_cfg_valid) begin
            unique case (bfmd_pkg::t_reg_index'(i_cfg_index))
                bfmd_pkg::REG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_data[7:0];
                bfmd_pkg::REG_MAX_BODY_LENGTH:  r_cfg.max_body_length  <= i_cfg_data;
                default:                        r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign in_item.rx_byte     = s_axis_tdata;
    assign in_item.link_closed = s_axis_tuser;

    // the held byte is parsed when the result register has room
    assign ctl.advance = held_valid && out_free;
    assign ctl.load    = has_result;

    bfmd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (ctl.advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    bfmd_parser #(
        .MAX_BODY_BYTES   (MAX_BODY_BYTES),
        .CODE_CHARS_MAX   (CODE_CHARS_MAX),
        .LENGTH_CHARS_MAX (LENGTH_CHARS_MAX)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (ctl.advance),
        .i_item       (held_item),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    bfmd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    assign m_axis_tdata = {7'b0000000, out_result.body_length, out_result.code_count,
                           out_result.code_chars, out_result.status,
                           out_result.data_byte};
    assign m_axis_tuser = out_result.has_byte;
    assign m_axis_tlast = out_result.end_of_message;

    // a clean end of message always carries the closing bar
    a_ok_end_is_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && m_axis_tuser
         && out_result.status == bfmd_pkg::ST_OK)
        |-> out_result.data_byte == bfmd_pkg::CHR_BAR)
        else $error("ok end of message without closing bar");

    // beats without a body byte are error reports that close the message
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser)
        |-> (m_axis_tlast && out_result.status != bfmd_pkg::ST_OK
             && out_result.body_length == '0 && out_result.data_byte == '0))
        else $error("malformed error beat");

    // a held byte is not dropped while the result register is blocked
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && !out_free) |=> held_valid)
        else $error("input byte lost under stall");

endmodule

@@ test/tb_bar_framed_message_deframer.sv @@
`timescale 1ns / 1ps

module tb_bar_framed_message_deframer;
    import bfmd_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN    = 10;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    t_reg_index             i_cfg_index;
    logic [LEN_W-1:0]       i_cfg_data;

    bar_framed_message_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // deframer state as predicted from the accepted bytes
    t_phase              dfr_phase;
    logic [FCOUNT_W-1:0] dfr_count;
    logic [CODE_W-1:0]   dfr_code;
    int                  dfr_len;
    bit                  dfr_ovf;
    bit                  dfr_stop;
    bit                  dfr_neg;
    logic [LEN_W-1:0]    dfr_left;
    logic [LEN_W-1:0]    dfr_declared;
    logic [7:0]          cfg_version;
    logic [LEN_W-1:0]    cfg_max_len;

    t_result    pending_results[$];
    logic [8:0] burst[$];   // {link_closed, byte} beats waiting to be sent
    int         sent_bytes;
    int         mismatches;
    bit         no_stall;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_frame();
        dfr_phase    = PH_IDLE;
        dfr_count    = '0;
        dfr_code     = '0;
        dfr_len      = 0;
        dfr_ovf      = 1'b0;
        dfr_stop     = 1'b0;
        dfr_neg      = 1'b0;
        dfr_left     = '0;
        dfr_declared = '0;
    endfunction

    // code_count follows the last nonzero stored code byte
    function automatic t_result frame_result(logic [7:0] b, bit has, bit eom, t_status st,
                                             logic [LEN_W-1:0] blen);
        t_result r;
        r.data_byte      = b;
        r.has_byte       = has;
        r.end_of_message = eom;
        r.status         = st;
        r.code_chars     = dfr_code;
        r.code_count     = 2'd0;
        if (dfr_code[23:16] != 8'h00) r.code_count = 2'd1;
        if (dfr_code[15:8] != 8'h00) r.code_count = 2'd2;
        if (dfr_code[7:0] != 8'h00) r.code_count = 2'd3;
        r.body_length    = blen;
        return r;
    endfunction

    function automatic void abort_frame(t_status st);
        pending_results.push_back(frame_result(8'h00, 1'b0, 1'b1, st, '0));
        clear_frame();
    endfunction

    function automatic void add_digit(logic [7:0] c);
        if (!dfr_ovf) begin
            dfr_len = dfr_len * 10 + (int'(c) - int'(CHR_ZERO));
            if (dfr_len > MAX_BODY_BYTES_DEF) begin
                dfr_ovf = 1'b1;
                dfr_len = 0;
            end
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] c, bit closed);
        bit digit;
        bit atoi_space;
        int lim;
        digit      = (c >= CHR_ZERO) && (c <= CHR_NINE);
        atoi_space = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) ||
                     (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
        if (closed) begin
            abort_frame(ST_DISC);
            return;
        end
        case (dfr_phase)
            PH_IDLE: begin
                if (c == CHR_LF || c == CHR_CR || c == CHR_SPACE) return;
                if (c != cfg_version) abort_frame(ST_VERSION);
                else dfr_phase = PH_VBAR;
            end
            PH_VBAR: begin
                if (c != CHR_BAR) begin
                    abort_frame(ST_ILL);
                end else begin
                    dfr_phase = PH_CODE;
                    dfr_count = '0;
                end
            end
            PH_CODE: begin
                if (c == CHR_BAR) begin
                    dfr_phase = PH_LEAD;
                    dfr_count = '0;
                end else if (dfr_count >= CODE_CHARS_MAX_DEF) begin
                    abort_frame(ST_ILL);
                end else begin
                    dfr_code  = dfr_code | ({16'h0000, c} << (16 - 8 * dfr_count));
                    dfr_count = dfr_count + 1'b1;
                end
            end
            PH_LEAD, PH_NUM: begin
                if (c == CHR_BAR) begin
                    lim = (cfg_max_len > MAX_BODY_BYTES_DEF) ? MAX_BODY_BYTES_DEF : cfg_max_len;
                    if (dfr_neg || dfr_ovf || dfr_len == 0 || dfr_len > lim) begin
                        abort_frame(ST_ILL);
                    end else begin
                        dfr_declared = dfr_len[LEN_W-1:0];
                        dfr_left     = dfr_len[LEN_W-1:0];
                        dfr_phase    = PH_BODY;
                    end
                end else if (dfr_count >= LENGTH_CHARS_MAX_DEF) begin
                    abort_frame(ST_ILL);
                end else begin
                    dfr_count = dfr_count + 1'b1;
                    if (dfr_phase == PH_LEAD) begin
                        if (!atoi_space) begin
                            dfr_phase = PH_NUM;
                            if (c == CHR_MINUS) dfr_neg = 1'b1;
                            else if (c == CHR_PLUS) dfr_neg = dfr_neg;
                            else if (digit) add_digit(c);
                            else dfr_stop = 1'b1;
                        end
                    end else if (!dfr_stop) begin
                        if (digit) add_digit(c);
                        else dfr_stop = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (dfr_left <= 1) begin
                    pending_results.push_back(frame_result(c, 1'b1, 1'b1,
                        (c == CHR_BAR) ? ST_OK : ST_ILL, dfr_declared));
                    clear_frame();
                end else begin
                    dfr_left = dfr_left - 1'b1;
                    pending_results.push_back(frame_result(c, 1'b1, 1'b0, ST_OK, dfr_declared));
                end
            end
            default: clear_frame();
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic string fmt_result(t_result r);
        return $sformatf("byte=%02h has=%0d eom=%0d status=%0d code=%06h count=%0d len=%0d",
                         r.data_byte, r.has_byte, r.end_of_message, r.status,
                         r.code_chars, r.code_count, r.body_length);
    endfunction

    function automatic void check_beat();
        t_result got;
        t_result want;
        bit      bad;
        got.data_byte      = m_axis_tdata[7:0];
        got.status         = t_status'(m_axis_tdata[9:8]);
        got.code_chars     = m_axis_tdata[33:10];
        got.code_count     = m_axis_tdata[35:34];
        got.body_length    = m_axis_tdata[48:36];
        got.has_byte       = m_axis_tuser;
        got.end_of_message = m_axis_tlast;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t: result beat with none expected: %s", $time, fmt_result(got));
            return;
        end
        want = pending_results.pop_front();
        bad = (got.data_byte != want.data_byte) || (got.has_byte != want.has_byte) ||
              (got.end_of_message != want.end_of_message) || (got.status != want.status) ||
              (got.code_chars != want.code_chars) || (got.code_count != want.code_count) ||
              (got.body_length != want.body_length);
        if (bad) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("%0t: result mismatch", $time);
                $display("  expected %s", fmt_result(want));
                $display("  actual   %s", fmt_result(got));
            end
        end
    endfunction

    // sample all handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_beat();
            if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata, s_axis_tuser);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_EXPECTED_VERSION) cfg_version = i_cfg_data[7:0];
                else cfg_max_len = i_cfg_data;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready = no_stall || ($urandom_range(99) >= 9);
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_byte(input logic [7:0] b, input bit closed);
        @(negedge i_clk);
        while (!no_stall && $urandom_range(99) < 9) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = closed;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    task automatic send_burst();
        foreach (burst[i]) send_byte(burst[i][7:0], burst[i][8]);
        burst.delete();
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [LEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // bring the block back to idle and let every result come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        if (dfr_phase != PH_IDLE) begin
            send_byte(8'($urandom_range(255)), 1'b1);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] ver, input int max_len);
        drain();
        write_reg(REG_EXPECTED_VERSION, {5'b00000, ver});
        write_reg(REG_MAX_BODY_LENGTH, max_len[LEN_W-1:0]);
    endtask

    // ---------------------------------------------------------------- stream building

    function automatic void put_byte(logic [7:0] b);
        burst.push_back({1'b0, b});
    endfunction

    function automatic void put_closed();
        burst.push_back({1'b1, 8'($urandom_range(255))});
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_decimal(int v);
        put_text($sformatf("%0d", v));
    endfunction

    function automatic logic [7:0] any_but_bar();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CHR_BAR);
        return b;
    endfunction

    // non-digit, non-bar byte that ends the number
    function automatic logic [7:0] junk_char();
        logic [7:0] b;
        b = any_but_bar();
        if (b >= CHR_ZERO && b <= CHR_NINE) b = 8'h78;
        return b;
    endfunction

    function automatic logic [7:0] pick_gap_char();
        case ($urandom_range(2))
            0: return CHR_LF;
            1: return CHR_CR;
            default: return CHR_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_atoi_space();
        case ($urandom_range(5))
            0: return CHR_SPACE;
            1: return CHR_TAB;
            2: return CHR_LF;
            3: return CHR_VT;
            4: return CHR_FF;
            default: return CHR_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_version();
        logic [7:0] v;
        do v = 8'($urandom_range(255));
        while (v == CHR_LF || v == CHR_CR || v == CHR_SPACE);
        return v;
    endfunction

    // one frame with random code, length spelling and body
    function automatic void build_random_frame(int max_len);
        int  blen;
        int  style;
        int  top;
        bit  too_long;
        repeat ($urandom_range(2)) put_byte(pick_gap_char());
        put_byte(cfg_version);
        put_byte(CHR_BAR);
        repeat ($urandom_range(3)) put_byte(any_but_bar());
        put_byte(CHR_BAR);
        style    = $urandom_range(99);
        top      = (style < 3) ? 300 : (style < 20) ? 64 : 8;
        if (top > max_len) top = max_len;
        blen     = $urandom_range(top, 1);
        too_long = (style >= 95);
        if (too_long) blen = max_len + $urandom_range(20, 1);
        style = $urandom_range(9);
        if (style == 0) begin
            repeat ($urandom_range(3)) put_byte(pick_atoi_space());
            put_byte(CHR_PLUS);
        end else if (style == 1) begin
            repeat ($urandom_range(3, 1)) put_byte(CHR_ZERO);
        end
        put_decimal(blen);
        if (style == 2) repeat ($urandom_range(3, 1)) put_byte(junk_char());
        put_byte(CHR_BAR);
        if (!too_long) begin
            repeat (blen - 1) put_byte(8'($urandom_range(255)));
            put_byte(($urandom_range(9) != 0) ? CHR_BAR : any_but_bar());
        end
    endfunction

    // mostly good frames, some noise, dropped links and damaged frames
    task automatic run_random(input int n_items);
        int stop_at;
        int roll;
        int pos;
        stop_at = sent_bytes + n_items;
        while (sent_bytes < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range(255)));
            end else if (roll < 12) begin
                put_closed();
            end else begin
                build_random_frame(int'(cfg_max_len));
                if (roll < 24) begin
                    pos = $urandom_range(burst.size() - 1);
                    burst[pos] = {1'b0, 8'($urandom_range(255))};
                end else if (roll < 28) begin
                    pos = $urandom_range(burst.size() - 1);
                    while (burst.size() > pos) void'(burst.pop_back());
                    put_closed();
                end
            end
            send_burst();
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_well_formed();
        put_text("1|AB|5|abcd|");
        put_byte(CHR_CR);
        put_byte(CHR_LF);
        put_text(" 1||1||");
        // code and body bytes at both extremes
        put_text("1|");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("Z|3|");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CHR_BAR);
        send_burst();
        drain();
    endtask

    task automatic test_header_errors();
        put_text("2");        // wrong version
        put_text("1x");       // no bar after version
        put_text("1|ABCD");   // code one char too long
        put_closed();         // link drops while idle
        put_text("1|AB");
        put_closed();         // link drops inside the header
        send_burst();
        drain();
    endtask

    task automatic test_length_field();
        // atoi whitespace, plus sign, digits, then bytes that only count
        put_text("1|L|");
        put_byte(CHR_TAB);
        put_byte(CHR_VT);
        put_byte(CHR_FF);
        put_byte(CHR_SPACE);
        put_byte(CHR_CR);
        put_byte(CHR_LF);
        put_text("+12ab|0123456789a|");
        put_text("1|L|-5|");
        put_text("1|L|0|");
        put_text("1|L||");
        put_text("1|L|x5|");
        put_text("1|L|4097|");
        put_text("1|L|99999|");
        put_text("1|L|000000000000002|q|");   // field exactly full
        put_text("1|L|0000000000000002|");    // one char over
        send_burst();
        drain();
    endtask

    task automatic test_body_end();
        put_text("1|B|3|ab!");     // last body byte is not a bar
        put_text("1|B|6|ab");
        put_closed();              // link drops inside the body
        // largest length the block takes; the link drops a few bytes in
        put_text("1|BIG|4096|");
        repeat (3) put_byte(8'($urandom_range(255)));
        put_closed();
        send_burst();
        drain();
    endtask

    task automatic test_register_extremes();
        // version byte equal to a skipped whitespace byte never matches
        set_config(CHR_SPACE, MAX_BODY_RST);
        put_text("  |A|1||");
        send_burst();
        set_config(8'h00, 1);
        put_byte(8'h00);
        put_text("|A|1||");
        put_byte(8'h00);
        put_text("|A|2|");
        send_burst();
        set_config(8'hFF, 4095);
        put_byte(8'hFF);
        put_text("|A|4096|");
        put_byte(8'hFF);
        put_text("|A|2|x|");
        send_burst();
        drain();
    endtask

    task automatic test_random_traffic();
        set_config(VERSION_RST, MAX_BODY_RST);
        run_random(280);
        set_config(pick_version(), $urandom_range(64, 1));
        run_random(280);
        set_config(8'hFF, 1);
        run_random(250);
        // long stretch with both sides always ready
        set_config(8'h00, MAX_BODY_RST);
        no_stall = 1'b1;
        run_random(300);
        drain();
        no_stall = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_EXPECTED_VERSION;
        i_cfg_data    = '0;
        no_stall      = 1'b0;
        sent_bytes    = 0;
        mismatches    = 0;
        cfg_version   = VERSION_RST;
        cfg_max_len   = MAX_BODY_RST;
        clear_frame();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_well_formed();
        test_header_errors();
        test_length_field();
        test_body_end();
        test_register_extremes();
        test_random_traffic();
        drain();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
